// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the true-peak meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TPM_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, also while reset is applied.
`define TPM_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/tpm_pkg.sv -----
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types and constants of the 4x true-peak meter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpm_pkg;

	// level width: 1/128 LSB units, unsigned
	localparam int LEVEL_W = 31;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
	localparam logic [LEVEL_W-1:0] CEILING_RESET = 31'd1342177280;

	// channel index width at the port
	localparam int CH_W = 3;

	// item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// per-item control that travels with the data
	typedef struct packed {
		logic clr;  // clear peak and histories
		logic smp;  // sample for an existing channel
	} tag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tpm_hist.sv -----
// ----------------------------------------------------------------------------
// tpm_hist
// Per-channel sample history: one row of three samples per channel in a
// memory, row valid bits for the clear, and forwarding for back-to-back
// items on the same channel. Holds the first pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpm_hist #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_s1,
	input  logic                          leave_s1,
	input  logic                          kind,
	input  logic [tpm_pkg::CH_W-1:0]      channel,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output tpm_pkg::tag_t                 tag_s1,
	output logic signed [SAMPLE_BITS-1:0] h0,
	output logic signed [SAMPLE_BITS-1:0] h1,
	output logic signed [SAMPLE_BITS-1:0] h2,
	output logic signed [SAMPLE_BITS-1:0] h3
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RW = 3 * SAMPLE_BITS;

	logic [RW-1:0]              hist_mem [CHANNELS];
	logic [RW-1:0]              rd_s1;
	logic [CHANNELS-1:0]        row_vld_q;

	logic                       clr_s1;
	logic                       smp_s1;
	logic [AW-1:0]              addr_s1;
	logic signed [SAMPLE_BITS-1:0] data_s1;
	logic                       fwd_s1;
	logic [RW-1:0]              fwd_row_s1;

	logic [AW+tpm_pkg::CH_W-1:0] ch_ext;
	logic                       ch_ok;
	logic [AW-1:0]              addr_in;
	logic [RW-1:0]              eff_row;
	logic [RW-1:0]              new_row;

	// channel decode at the input
	assign ch_ext  = {{AW{1'b0}}, channel};
	assign ch_ok   = ($unsigned(32'(channel)) < $unsigned(32'(CHANNELS)));
	assign addr_in = ch_ok ? ch_ext[AW-1:0] : '0;

	// stage 1 item register
	always_ff @(posedge clk) begin
		if (load_s1) begin
			clr_s1     <= (kind == tpm_pkg::KIND_CLEAR);
			smp_s1     <= (kind == tpm_pkg::KIND_SAMPLE) && ch_ok;
			addr_s1    <= addr_in;
			data_s1    <= sample;
			// row being written back this edge is the row being read
			fwd_s1     <= leave_s1 && smp_s1 && (addr_s1 == addr_in);
			fwd_row_s1 <= new_row;
		end
	end

	// history memory: read at accept, write when the item leaves stage 1
	always_ff @(posedge clk) begin
		if (load_s1) begin
			rd_s1 <= hist_mem[addr_in];
		end
		if (leave_s1 && smp_s1) begin
			hist_mem[addr_s1] <= new_row;
		end
	end

	// row valid bits; an invalid row reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (leave_s1 && clr_s1) begin
			row_vld_q <= '0;
		end else if (leave_s1 && smp_s1) begin
			row_vld_q[addr_s1] <= 1'b1;
		end
	end

	// effective history row
	always_comb begin
		if (fwd_s1) begin
			eff_row = fwd_row_s1;
		end else if (row_vld_q[addr_s1]) begin
			eff_row = rd_s1;
		end else begin
			eff_row = '0;
		end
	end

	assign h0      = eff_row[RW-1 -: SAMPLE_BITS];
	assign h1      = eff_row[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
	assign h2      = eff_row[SAMPLE_BITS-1:0];
	assign h3      = data_s1;
	assign new_row = {h1, h2, h3};

	assign tag_s1.clr = clr_s1;
	assign tag_s1.smp = smp_s1;

	`TPM_CHECK(a_clear_drops_rows, leave_s1 && clr_s1 |=> row_vld_q == '0,
		"clear item left history rows valid")
	`TPM_CHECK(a_write_marks_row, leave_s1 && smp_s1 |=> row_vld_q[$past(addr_s1)],
		"written history row not marked valid")

endmodule

`default_nettype wire

// ----- hw/rtl/tpm_interp.sv -----
// ----------------------------------------------------------------------------
// tpm_interp
// Catmull-Rom interpolation at t = 1/4, 1/2, 3/4 in 1/128 LSB units.
// Stage 2 forms the cubic coefficients, stage 3 the four level candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module tpm_interp #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                             clk,
	input  logic                             ld_s2,
	input  logic                             ld_s3,
	input  tpm_pkg::tag_t                    tag_s1,
	input  logic signed [SAMPLE_BITS-1:0]    h0,
	input  logic signed [SAMPLE_BITS-1:0]    h1,
	input  logic signed [SAMPLE_BITS-1:0]    h2,
	input  logic signed [SAMPLE_BITS-1:0]    h3,
	output tpm_pkg::tag_t                    tag_s3,
	output logic signed [SAMPLE_BITS+10:0]   v0,
	output logic signed [SAMPLE_BITS+10:0]   v1,
	output logic signed [SAMPLE_BITS+10:0]   v2,
	output logic signed [SAMPLE_BITS+10:0]   v3
);

	// coefficient width (|a2| <= 12 * 2^(SB-1)) and level width
	localparam int CW = SAMPLE_BITS + 4;
	localparam int VW = SAMPLE_BITS + 11;

	logic signed [CW-1:0]          e0, e1, e2, e3;
	logic signed [CW-1:0]          d_c, a2_c, a3_c;

	tpm_pkg::tag_t                 tag_s2;
	logic signed [SAMPLE_BITS-1:0] h1_s2, h3_s2;
	logic signed [CW-1:0]          d_s2, a2_s2, a3_s2;

	logic signed [VW-1:0]          x1, x3, xd, xa2, xa3;
	logic signed [VW-1:0]          v0_c, v1_c, v2_c, v3_c;
	logic signed [VW-1:0]          v0_s3, v1_s3, v2_s3, v3_s3;

	// cubic coefficients
	always_comb begin
		e0   = CW'(h0);
		e1   = CW'(h1);
		e2   = CW'(h2);
		e3   = CW'(h3);
		d_c  = e2 - e0;
		a2_c = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
		a3_c = e1 + (e1 <<< 1) - e0 - e2 - (e2 <<< 1) + e3;
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			tag_s2 <= tag_s1;
			h1_s2  <= h1;
			h3_s2  <= h3;
			d_s2   <= d_c;
			a2_s2  <= a2_c;
			a3_s2  <= a3_c;
		end
	end

	// v(k) = 128 h1 + 16k d + 4k^2 a2 + k^3 a3, plus the new sample at 128 h3
	always_comb begin
		x1   = VW'(h1_s2);
		x3   = VW'(h3_s2);
		xd   = VW'(d_s2);
		xa2  = VW'(a2_s2);
		xa3  = VW'(a3_s2);
		v0_c = x3 <<< 7;
		v1_c = (x1 <<< 7) + (xd <<< 4) + (xa2 <<< 2) + xa3;
		v2_c = (x1 <<< 7) + (xd <<< 5) + (xa2 <<< 4) + (xa3 <<< 3);
		v3_c = (x1 <<< 7) + (xd <<< 5) + (xd <<< 4) + (xa2 <<< 5) + (xa2 <<< 2)
			+ (xa3 <<< 4) + (xa3 <<< 3) + (xa3 <<< 1) + xa3;
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			tag_s3 <= tag_s2;
			v0_s3  <= v0_c;
			v1_s3  <= v1_c;
			v2_s3  <= v2_c;
			v3_s3  <= v3_c;
		end
	end

	assign v0 = v0_s3;
	assign v1 = v1_s3;
	assign v2 = v2_s3;
	assign v3 = v3_s3;

endmodule

`default_nettype wire

// ----- hw/rtl/tpm_peak.sv -----
// ----------------------------------------------------------------------------
// tpm_peak
// Magnitude and saturation of the four candidates (stage 4), then the
// running peak and the ceiling flag in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpm_peak #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ld_s4,
	input  logic                           ld_out,
	input  tpm_pkg::tag_t                  tag_s3,
	input  logic signed [SAMPLE_BITS+10:0] v0,
	input  logic signed [SAMPLE_BITS+10:0] v1,
	input  logic signed [SAMPLE_BITS+10:0] v2,
	input  logic signed [SAMPLE_BITS+10:0] v3,
	input  logic [tpm_pkg::LEVEL_W-1:0]    ceiling,
	output logic [tpm_pkg::LEVEL_W-1:0]    peak_level,
	output logic                           over_ceiling
);

	localparam int VW = SAMPLE_BITS + 11;
	localparam int LW = tpm_pkg::LEVEL_W;
	localparam int NC = 5;

	logic signed [VW-1:0]   vin [4];
	logic [LW-1:0]          mag_c [4];
	logic [LW-1:0]          mag_s4 [4];
	tpm_pkg::tag_t          tag_s4;

	logic [LW-1:0]          cand [NC];
	logic [NC-1:0]          win;
	logic [NC-1:0]          above;
	logic [LW-1:0]          new_peak;
	logic                   new_over;

	logic [LW-1:0]          peak_q;
	logic                   over_q;

	assign vin[0] = v0;
	assign vin[1] = v1;
	assign vin[2] = v2;
	assign vin[3] = v3;

	// absolute value, saturated to the level range
	always_comb begin
		logic [VW-1:0]    absv;
		logic [VW+LW-1:0] wide;
		for (int i = 0; i < 4; i++) begin
			absv     = vin[i][VW-1] ? VW'(-vin[i]) : VW'(vin[i]);
			wide     = {{LW{1'b0}}, absv};
			mag_c[i] = (|wide[VW+LW-1:LW]) ? tpm_pkg::LEVEL_MAX : wide[LW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			tag_s4 <= tag_s3;
			for (int i = 0; i < 4; i++) begin
				mag_s4[i] <= mag_c[i];
			end
		end
	end

	// maximum of the candidates and the stored peak, all compares in parallel
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cand[i] = tag_s4.smp ? mag_s4[i] : '0;
		end
		cand[4] = peak_q;
		for (int i = 0; i < NC; i++) begin
			win[i]   = 1'b1;
			above[i] = (cand[i] > ceiling);
			for (int j = 0; j < NC; j++) begin
				if (j < i) begin
					win[i] = win[i] & (cand[i] > cand[j]);
				end else if (j > i) begin
					win[i] = win[i] & (cand[i] >= cand[j]);
				end
			end
		end
		new_peak = '0;
		for (int i = 0; i < NC; i++) begin
			new_peak = new_peak | (win[i] ? cand[i] : '0);
		end
		new_over = |(win & above);
	end

	// result register, also the peak store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			over_q <= 1'b0;
		end else if (ld_out) begin
			if (tag_s4.clr) begin
				peak_q <= '0;
				over_q <= 1'b0;
			end else begin
				peak_q <= new_peak;
				over_q <= new_over;
			end
		end
	end

	assign peak_level   = peak_q;
	assign over_ceiling = over_q;

	`TPM_CHECK(a_clear_zeroes_peak, ld_out && tag_s4.clr |=> peak_q == '0 && !over_q,
		"clear item did not zero the peak")
	`TPM_CHECK(a_peak_monotonic, ld_out && !tag_s4.clr |=> peak_q >= $past(peak_q),
		"peak fell without a clear item")
	`TPM_CHECK(a_flag_matches, ld_out |=> over_q == (peak_q > $past(ceiling)),
		"ceiling flag disagrees with peak")

endmodule

`default_nettype wire

// ----- hw/rtl/true_peak_meter_cubic_4x_core.sv -----
// ----------------------------------------------------------------------------
// true_peak_meter_cubic_4x_core
// 4x true-peak meter: Catmull-Rom interpolation per channel, shared peak.
// ----------------------------------------------------------------------------
// Each accepted item gives one result. A sample item shifts the sample into
// its channel's three-sample history, interpolates three points between the
// two middle history samples, and raises the shared peak to the largest
// magnitude of the new sample and the three points (1/128 LSB units,
// saturating at 2^31-1). A clear item zeroes the peak and all histories and
// reports zero. A sample for a channel at or above CHANNELS leaves all state
// unchanged. One item is accepted every cycle while smp_stall is low; its
// result passes a five-register pipeline (history read, coefficients, points,
// magnitudes, peak), with one history-memory read and one write per cycle and
// forwarding for the same channel back to back. A stall on the result side
// fills the pipeline before the input stalls. History rows carry valid bits,
// so there is no clearing pass after reset. The user must write the ceiling
// register through the cfg port (always ready) only while the block is idle;
// the block does not check it. over_ceiling is set when peak_level exceeds it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module true_peak_meter_cubic_4x_core #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          smp_valid,
	output logic                          smp_stall,
	input  logic                          kind,
	input  logic [tpm_pkg::CH_W-1:0]      channel,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [tpm_pkg::LEVEL_W-1:0]   peak_level,
	output logic                          over_ceiling,
	// ceiling register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tpm_pkg::LEVEL_W-1:0]   cfg_data
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, res_vld_q;
	logic en1, en2, en3, en4, en_out;
	logic accept;

	logic [tpm_pkg::LEVEL_W-1:0] ceiling_q;

	tpm_pkg::tag_t                 tag_s1, tag_s3;
	logic signed [SAMPLE_BITS-1:0] h0, h1, h2, h3;
	logic signed [SAMPLE_BITS+10:0] v0, v1, v2, v3;

	// stage enables: a stage moves when it is empty or the next one moves
	assign en_out    = !res_vld_q || !res_stall;
	assign en4       = !vld_s4 || en_out;
	assign en3       = !vld_s3 || en4;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign smp_stall = !en1;
	assign accept    = smp_valid && en1;
	assign res_valid = res_vld_q;

	// pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= smp_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
			if (en4) begin
				vld_s4 <= vld_s3;
			end
			if (en_out) begin
				res_vld_q <= vld_s4;
			end
		end
	end

	// ceiling register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= tpm_pkg::CEILING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ceiling_q <= cfg_data;
		end
	end

	tpm_hist #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_s1  (accept),
		.leave_s1 (vld_s1 && en2),
		.kind     (kind),
		.channel  (channel),
		.sample   (sample),
		.tag_s1   (tag_s1),
		.h0       (h0),
		.h1       (h1),
		.h2       (h2),
		.h3       (h3)
	);

	tpm_interp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_interp (
		.clk    (clk),
		.ld_s2  (en2),
		.ld_s3  (en3),
		.tag_s1 (tag_s1),
		.h0     (h0),
		.h1     (h1),
		.h2     (h2),
		.h3     (h3),
		.tag_s3 (tag_s3),
		.v0     (v0),
		.v1     (v1),
		.v2     (v2),
		.v3     (v3)
	);

	tpm_peak #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_peak (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld_s4        (en4),
		.ld_out       (vld_s4 && en_out),
		.tag_s3       (tag_s3),
		.v0           (v0),
		.v1           (v1),
		.v2           (v2),
		.v3           (v3),
		.ceiling      (ceiling_q),
		.peak_level   (peak_level),
		.over_ceiling (over_ceiling)
	);

	`TPM_CHECK_ALWAYS(a_empty_takes_item, !vld_s1 |-> !smp_stall,
		"input stalled with an empty first stage")

endmodule

`default_nettype wire

// ----- verif/true_peak_meter_cubic_4x_core_tb.sv -----
// ----------------------------------------------------------------------------
// true_peak_meter_cubic_4x_core_tb
// Self-checking testbench for the 4x Catmull-Rom true-peak meter.
// ----------------------------------------------------------------------------
// Each accepted item runs through a local meter model that keeps the
// per-channel histories, the shared peak and the ceiling. The model queues the
// reading the block should return, and every returned reading is compared
// against the oldest one in the queue. The test starts with directed extremes
// and ceiling boundary cases. It then runs random phases with different
// sender idle and receiver stall rates, and ends with a long result-side
// hold-off while the sender keeps offering items.
// ----------------------------------------------------------------------------

module true_peak_meter_cubic_4x_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS     = 8;
	localparam int SAMPLE_BITS  = 24;
	localparam int CH_W         = tpm_pkg::CH_W;
	localparam int LEVEL_W      = tpm_pkg::LEVEL_W;
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int STALL_LIMIT  = 5000;  // cycles with no item moving
	localparam int DRAIN_CYCLES = 8;     // pipeline is five deep

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;
	// full-scale sample in 1/128 LSB units
	localparam logic [LEVEL_W-1:0] FULL_SCALE_LEVEL = 31'd1073741696;

	typedef struct {
		logic [LEVEL_W-1:0] peak;
		logic               over;
	} reading_t;

	logic                          clk;
	logic                          arst_n;
	logic                          smp_valid;
	logic                          smp_stall;
	logic                          kind;
	logic [CH_W-1:0]               channel;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          res_valid;
	logic                          res_stall;
	logic [LEVEL_W-1:0]            peak_level;
	logic                          over_ceiling;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [LEVEL_W-1:0]            cfg_data;

	// meter model state
	longint             hist [CHANNELS][3];
	longint             peak_now;
	logic [LEVEL_W-1:0] ceiling_now;
	reading_t           readings_due [$];

	// traffic shaping
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;

	int n_samples = 0;
	int n_clears  = 0;
	int n_cfg     = 0;
	int n_checked = 0;
	int n_errors  = 0;

	true_peak_meter_cubic_4x_core #(
		.CHANNELS   (CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.smp_valid   (smp_valid),
		.smp_stall   (smp_stall),
		.kind        (kind),
		.channel     (channel),
		.sample      (sample),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.peak_level  (peak_level),
		.over_ceiling(over_ceiling),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------- model

	function automatic longint magnitude(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// running peak, saturating at the level width
	function automatic void raise_peak(longint m);
		if (m > longint'(tpm_pkg::LEVEL_MAX))
			m = longint'(tpm_pkg::LEVEL_MAX);
		if (m > peak_now)
			peak_now = m;
	endfunction

	// one item through the meter; returns the reading it produces
	function automatic reading_t meter_step(logic k, logic [CH_W-1:0] ch,
			logic signed [SAMPLE_BITS-1:0] s);
		longint   h0, h1, h2, h3, a2, a3, v;
		reading_t r;
		if (k == tpm_pkg::KIND_CLEAR) begin
			foreach (hist[i, j])
				hist[i][j] = 0;
			peak_now = 0;
		end else if (ch < CHANNELS) begin
			h0 = hist[ch][0];
			h1 = hist[ch][1];
			h2 = hist[ch][2];
			h3 = s;
			a2 = 2 * h0 - 5 * h1 + 4 * h2 - h3;
			a3 = -h0 + 3 * h1 - 3 * h2 + h3;
			raise_peak(magnitude(h3) * 128);
			// points at t = 1/4, 1/2, 3/4, scaled by 128
			for (int t = 1; t <= 3; t++) begin
				v = 128 * h1 + 16 * t * (h2 - h0) + 4 * t * t * a2 + t * t * t * a3;
				raise_peak(magnitude(v));
			end
			hist[ch][0] = h1;
			hist[ch][1] = h2;
			hist[ch][2] = h3;
		end
		r.peak = peak_now[LEVEL_W-1:0];
		r.over = (peak_now > longint'(ceiling_now));
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// offer one item, with random idle cycles ahead of it
	task automatic send_item(logic k, logic [CH_W-1:0] ch,
			logic signed [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			smp_valid <= 1'b0;
			@(posedge clk);
		end
		smp_valid <= 1'b1;
		kind      <= k;
		channel   <= ch;
		sample    <= s;
		do
			@(posedge clk);
		while (smp_stall);
		readings_due.push_back(meter_step(k, ch, s));
		if (k == tpm_pkg::KIND_CLEAR)
			n_clears++;
		else
			n_samples++;
	endtask

	// ceiling write, only once every outstanding reading is back
	task automatic write_ceiling(logic [LEVEL_W-1:0] val);
		smp_valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid   <= 1'b0;
		ceiling_now = val;
		n_cfg++;
	endtask

	// sample within +/- 2^amp, with occasional full-scale values
	function automatic logic signed [SAMPLE_BITS-1:0] random_sample(int amp);
		longint lim;
		int     r;
		r = $urandom_range(99);
		if (r < 3)
			return SMP_MAX;
		if (r < 6)
			return SMP_MIN;
		lim = (longint'(1) << amp) - 1;
		return SAMPLE_BITS'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
	endfunction

	// ceiling spread over many octaves so the flag goes both ways
	function automatic logic [LEVEL_W-1:0] random_ceiling();
		return LEVEL_W'($urandom_range(0, 32'(tpm_pkg::CEILING_RESET))
			>> $urandom_range(0, 16));
	endfunction

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin : check_result
		reading_t want;
		if (arst_n && res_valid && !res_stall) begin
			n_checked++;
			if (readings_due.size() == 0) begin
				$error("unexpected result: peak_level %0d over_ceiling %0d",
					peak_level, over_ceiling);
				n_errors++;
			end else begin
				want = readings_due.pop_front();
				if (peak_level !== want.peak) begin
					$error("peak_level: expected %0d, actual %0d", want.peak, peak_level);
					n_errors++;
				end
				if (over_ceiling !== want.over) begin
					$error("over_ceiling: expected %0d, actual %0d",
						want.over, over_ceiling);
					n_errors++;
				end
			end
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin : result_side
		int hold_left;
		bit hold_taken;
		if (hold_req && !hold_taken) begin
			hold_left  = HOLD_CYCLES;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog: ends the run when no item moves for too long
	always @(posedge clk) begin : watchdog
		int quiet;
		if ((smp_valid && !smp_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", quiet);
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// extremes, clear with junk fields, every channel
	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct     = 0;
		// alternating full scale: largest overshoot
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(0), SMP_MAX);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(0), SMP_MIN);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(0), SMP_MAX);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(0), SMP_MIN);
		// clear ignores channel and sample
		send_item(tpm_pkg::KIND_CLEAR, CH_W'(3), SMP_MIN);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(7), SMP_MIN);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(7), SMP_MIN);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(1), 24'sd1);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(1), -24'sd1);
		for (int c = 2; c <= 6; c++)
			send_item(tpm_pkg::KIND_SAMPLE, CH_W'(c), SAMPLE_BITS'(c * 1000 - 3500));
	endtask

	// flag at ceiling zero and at the full-scale boundary
	task automatic test_ceiling_extremes();
		write_ceiling('0);
		send_item(tpm_pkg::KIND_CLEAR, CH_W'(0), '0);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(4), '0);     // peak 0 is not above 0
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(4), 24'sd1);
		write_ceiling(LEVEL_W'(FULL_SCALE_LEVEL - 1));
		send_item(tpm_pkg::KIND_CLEAR, CH_W'(5), SMP_MAX);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(0), SMP_MAX);
		write_ceiling(FULL_SCALE_LEVEL);   // equal is not over
		send_item(tpm_pkg::KIND_CLEAR, CH_W'(6), 24'sd5);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(0), SMP_MAX);
		write_ceiling(tpm_pkg::CEILING_RESET);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(6), SMP_MIN);
		send_item(tpm_pkg::KIND_SAMPLE, CH_W'(6), SMP_MAX);
	endtask

	// random samples with clears; amplitude changes after each clear
	task automatic test_random(int count, int idle, int stall);
		int amp;
		write_ceiling(random_ceiling());
		send_idle_pct = idle;
		stall_pct     = stall;
		amp           = $urandom_range(4, 23);
		repeat (count) begin
			if ($urandom_range(99) < 3) begin
				send_item(tpm_pkg::KIND_CLEAR, CH_W'($urandom), SAMPLE_BITS'($urandom));
				amp = $urandom_range(4, 23);
			end else begin
				send_item(tpm_pkg::KIND_SAMPLE, CH_W'($urandom), random_sample(amp));
			end
		end
	endtask

	// receiver holds off while the sender keeps going
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 1'b1;
		repeat (60)
			send_item(tpm_pkg::KIND_SAMPLE, CH_W'($urandom), random_sample(23));
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		arst_n    <= 1'b0;
		smp_valid <= 1'b0;
		kind      <= tpm_pkg::KIND_SAMPLE;
		channel   <= '0;
		sample    <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		foreach (hist[i, j])
			hist[i][j] = 0;
		peak_now    = 0;
		ceiling_now = tpm_pkg::CEILING_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_ceiling_extremes();
		test_random(400, 0, 0);
		test_random(400, 58, 0);
		test_random(400, 0, 58);
		test_random(400, 10, 10);
		test_backpressure();

		// drain
		smp_valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d samples and %0d clears over %0d channels, %0d ceiling values,",
			n_samples, n_clears, CHANNELS, n_cfg);
		$display("idle/stall phases and a long result hold-off; %0d readings checked, %0d errors.",
			n_checked, n_errors);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
